FILE: design/rarmt_pkg.sv
package rarmt_pkg;

    localparam int DATA_W = 32;
    localparam logic [DATA_W-1:0] EMPTY_MIN = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RET,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        STK_NONE,
        STK_PUSH,
        STK_LEFT,
        STK_POP
    } t_stk_op;

    // Signed minimum of two 32-bit words.
    function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

endpackage

FILE: design/rarmt_ram.sv
module rarmt_ram import rarmt_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rarmt_stack.sv
module rarmt_stack import rarmt_pkg::*; #(
    parameter int NW = 11,
    parameter int IW = 9,
    parameter int SD = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stk_op           i_op,
    input  logic [NW-1:0]     i_node,
    input  logic [IW-1:0]     i_lo,
    input  logic [IW-1:0]     i_hi,
    input  logic [DATA_W-1:0] i_tag,
    input  logic [DATA_W-1:0] i_min,
    input  logic [DATA_W-1:0] i_left,
    output logic              o_empty,
    output logic              o_phase,
    output logic [NW-1:0]     o_node,
    output logic [IW-1:0]     o_lo,
    output logic [IW-1:0]     o_hi,
    output logic [DATA_W-1:0] o_tag,
    output logic [DATA_W-1:0] o_min,
    output logic [DATA_W-1:0] o_left
);

    localparam int SPW = $clog2(SD + 1);
    localparam int XW  = $clog2(SD);

    typedef struct packed {
        logic              phase;
        logic [NW-1:0]     node;
        logic [IW-1:0]     lo;
        logic [IW-1:0]     hi;
        logic [DATA_W-1:0] tag;
        logic [DATA_W-1:0] min;
        logic [DATA_W-1:0] left;
    } t_frame;

    t_frame         r_stk [SD];
    logic [SPW-1:0] r_sp;
    logic [XW-1:0]  push_idx;
    logic [XW-1:0]  top_idx;
    t_frame         top;

    assign push_idx = r_sp[XW-1:0];
    assign top_idx  = XW'(r_sp - SPW'(1));
    assign top      = r_stk[top_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            unique case (i_op)
                STK_PUSH: r_sp <= r_sp + SPW'(1);
                STK_POP:  r_sp <= r_sp - SPW'(1);
                default:  r_sp <= r_sp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == STK_PUSH) begin
            r_stk[push_idx] <= '{phase: 1'b0, node: i_node, lo: i_lo, hi: i_hi,
                                 tag: i_tag, min: i_min, left: '0};
        end else if (i_op == STK_LEFT) begin
            r_stk[top_idx].phase <= 1'b1;
            r_stk[top_idx].left  <= i_left;
        end
    end

    assign o_empty = (r_sp == '0);
    assign o_phase = top.phase;
    assign o_node  = top.node;
    assign o_lo    = top.lo;
    assign o_hi    = top.hi;
    assign o_tag   = top.tag;
    assign o_min   = top.min;
    assign o_left  = top.left;

endmodule

FILE: design/range_add_range_min_tree.sv
// Lazy segment tree: range add and range minimum over up to MAX_ELEMENTS elements.
// One command at a time: a load takes the beat and then stalls the input while the buffer write lands;
// add and query step each visited node through read, evaluate and return, and a query then loads
// the result register; build reads each loaded element from the buffer into its leaf.
// Reset (i_rst_n, synchronous, active low) clears control and sets element_count to 1;
// memories are not cleared and hold garbage until loaded and built.
module range_add_range_min_tree import rarmt_pkg::*; #(
    parameter int MAX_ELEMENTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [8:0]         i_first_index,
    input  logic [8:0]         i_last_index,
    input  logic signed [31:0] i_operand_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_range_minimum,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW  = $clog2(MAX_ELEMENTS);       // element index width
    localparam int NW  = $clog2(4 * MAX_ELEMENTS);   // node index width
    localparam int CW  = ((IW > 9) ? IW : 9) + 1;    // common compare width
    localparam int LW  = ((IW > 10) ? IW : 10) + 2;  // count compare width
    localparam int SD  = IW + 1;                     // stack depth (partial nodes on a path)

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [8:0]        r_qa, n_qa;
    logic [8:0]        r_qb, n_qb;
    logic [DATA_W-1:0] r_val, n_val;
    logic [NW-1:0]     r_cur, n_cur;
    logic [IW-1:0]     r_lo, n_lo;
    logic [IW-1:0]     r_hi, n_hi;
    logic [DATA_W-1:0] r_p, n_p;       // tag inherited from the parent
    logic [DATA_W-1:0] r_ret, n_ret;   // value returned by the last finished node
    logic [9:0]        r_count;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_omin;

    // ---------------------------------------------------------------
    // Register port: element_count only
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {22'd0, r_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 10'd1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_count <= pwdata[9:0];
        end
    end

    // Root range end: count of 0 acts as 1, count above the capacity is clamped.
    logic [LW-1:0] cnt_w;
    logic [IW-1:0] root_hi;

    assign cnt_w = LW'(r_count);

    always_comb begin
        if (cnt_w == '0) begin
            root_hi = '0;
        end else if (cnt_w > LW'(MAX_ELEMENTS)) begin
            root_hi = IW'(MAX_ELEMENTS - 1);
        end else begin
            root_hi = IW'(cnt_w - LW'(1));
        end
    end

    // ---------------------------------------------------------------
    // Memories: node memory holds {tag, min}; element buffer holds loaded values
    // ---------------------------------------------------------------
    logic                  node_we, node_re;
    logic [NW-1:0]         node_waddr;
    logic [2*DATA_W-1:0]   node_wdata, node_rdata;
    logic                  buf_we, buf_re;
    logic [IW-1:0]         buf_waddr, buf_raddr;
    logic [DATA_W-1:0]     buf_rdata;

    rarmt_ram #(.WIDTH(2 * DATA_W), .DEPTH(4 * MAX_ELEMENTS)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (r_cur),
        .o_rdata (node_rdata)
    );

    rarmt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (r_val),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Buffer write data is the registered value: a load lands in the cycle after its beat.

    // ---------------------------------------------------------------
    // Traversal stack: one frame per partially covered (or, in a build, internal) node on the path
    // ---------------------------------------------------------------
    t_stk_op           stk_op;
    logic [DATA_W-1:0] stk_tag_in, stk_min_in;
    logic              stk_empty, stk_phase;
    logic [NW-1:0]     stk_node;
    logic [IW-1:0]     stk_lo, stk_hi;
    logic [DATA_W-1:0] stk_tag, stk_min, stk_left;

    rarmt_stack #(.NW(NW), .IW(IW), .SD(SD)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stk_op),
        .i_node  (r_cur),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_tag   (stk_tag_in),
        .i_min   (stk_min_in),
        .i_left  (r_ret),
        .o_empty (stk_empty),
        .o_phase (stk_phase),
        .o_node  (stk_node),
        .o_lo    (stk_lo),
        .o_hi    (stk_hi),
        .o_tag   (stk_tag),
        .o_min   (stk_min),
        .o_left  (stk_left)
    );

    // ---------------------------------------------------------------
    // Node geometry and range tests
    // ---------------------------------------------------------------
    logic          in_acc;
    logic [IW:0]   cur_sum, top_sum;
    logic [IW-1:0] cur_mid, top_mid;
    logic [NW-1:0] cur_left, top_right;
    logic          seg_out, seg_cov, leaf;
    logic [DATA_W-1:0] rd_tag, rd_min, eff_tag, eff_min, add_min, child_min;
    logic          out_ld;
    logic          load_pending;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || load_pending;

    assign cur_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign cur_mid   = cur_sum[IW:1];
    assign top_sum   = {1'b0, stk_lo} + {1'b0, stk_hi};
    assign top_mid   = top_sum[IW:1];
    assign cur_left  = {r_cur[NW-2:0], 1'b1};
    assign top_right = NW'({stk_node, 1'b0} + {{NW{1'b0}}, 1'b1} + {{NW{1'b0}}, 1'b1});

    assign seg_out = (CW'(r_qa) > CW'(r_hi)) || (CW'(r_qb) < CW'(r_lo));
    assign seg_cov = (CW'(r_qa) <= CW'(r_lo)) && (CW'(r_qb) >= CW'(r_hi));
    assign leaf    = (r_lo == r_hi);

    // Tag handed down from the parent lands on both the tag and the minimum.
    assign rd_tag    = node_rdata[2*DATA_W-1:DATA_W];
    assign rd_min    = node_rdata[DATA_W-1:0];
    assign eff_tag   = rd_tag + r_p;
    assign eff_min   = rd_min + r_p;
    assign add_min   = eff_min + r_val;
    assign child_min = smin(stk_left, r_ret);

    // ---------------------------------------------------------------
    // Load: capture the beat, write the buffer in the following cycle
    // ---------------------------------------------------------------
    logic          r_load_we;
    logic [IW-1:0] r_load_addr;

    assign load_pending = r_load_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_we <= 1'b0;
        end else begin
            r_load_we <= in_acc && (t_cmd'(i_command) == CMD_LOAD)
                         && (CW'(i_first_index) < CW'(MAX_ELEMENTS));
        end
    end

    always_ff @(posedge i_clk) begin
        r_load_addr <= IW'(i_first_index);
    end

    assign buf_we    = r_load_we;
    assign buf_waddr = r_load_addr;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_cmd'(i_command))
                        CMD_LOAD:  n_state = S_IDLE;
                        CMD_BUILD: n_state = S_READ;
                        CMD_ADD:   n_state = (i_first_index <= i_last_index) ? S_READ : S_IDLE;
                        CMD_QUERY: n_state = (i_first_index <= i_last_index) ? S_READ : S_OUT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if ((r_cmd == CMD_BUILD) && !leaf) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if ((r_cmd != CMD_BUILD) && !seg_out && !seg_cov) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_RET;
                end
            end
            S_RET: begin
                if (stk_empty) begin
                    n_state = (r_cmd == CMD_QUERY) ? S_OUT : S_IDLE;
                end else if (!stk_phase) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_RET;
                end
            end
            S_OUT: begin
                n_state = (!r_ovalid || !i_out_stall) ? S_IDLE : S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and memory control
    // Each visited node is read at most once (never during a build) and written once
    // per command, and a node is never read in the cycle it is written, so no forwarding is needed.
    // ---------------------------------------------------------------
    always_comb begin
        n_cmd      = r_cmd;
        n_qa       = r_qa;
        n_qb       = r_qb;
        n_val      = r_val;
        n_cur      = r_cur;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_p        = r_p;
        n_ret      = r_ret;
        node_we    = 1'b0;
        node_re    = 1'b0;
        node_waddr = r_cur;
        node_wdata = '0;
        buf_re     = 1'b0;
        buf_raddr  = r_lo;
        stk_op     = STK_NONE;
        stk_tag_in = '0;
        stk_min_in = '0;
        out_ld     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = t_cmd'(i_command);
                    n_qa  = i_first_index;
                    n_qb  = i_last_index;
                    n_val = i_operand_value;
                    n_cur = '0;
                    n_lo  = '0;
                    n_hi  = root_hi;
                    n_p   = '0;
                    n_ret = EMPTY_MIN;
                end
            end
            S_READ: begin
                if (r_cmd == CMD_BUILD) begin
                    if (leaf) begin
                        buf_re = 1'b1;
                    end else begin
                        // descend left, keep the node on the stack
                        stk_op = STK_PUSH;
                        n_cur  = cur_left;
                        n_hi   = cur_mid;
                    end
                end else begin
                    node_re = 1'b1;
                end
            end
            S_EVAL: begin
                if (r_cmd == CMD_BUILD) begin
                    node_we    = 1'b1;
                    node_wdata = {{DATA_W{1'b0}}, buf_rdata};
                    n_ret      = buf_rdata;
                end else if (seg_out) begin
                    // outside: take the handed-down tag and return
                    node_we    = 1'b1;
                    node_wdata = {eff_tag, eff_min};
                    n_ret      = (r_cmd == CMD_QUERY) ? EMPTY_MIN : eff_min;
                end else if (seg_cov) begin
                    node_we = 1'b1;
                    if (r_cmd == CMD_ADD) begin
                        node_wdata = {eff_tag + r_val, add_min};
                        n_ret      = add_min;
                    end else begin
                        node_wdata = {eff_tag, eff_min};
                        n_ret      = eff_min;
                    end
                end else begin
                    // partial: hand the tag down to both children
                    stk_op     = STK_PUSH;
                    stk_tag_in = eff_tag;
                    stk_min_in = eff_min;
                    n_cur      = cur_left;
                    n_hi       = cur_mid;
                    n_p        = eff_tag;
                end
            end
            S_RET: begin
                if (!stk_empty) begin
                    if (!stk_phase) begin
                        // left child done, advance to the right child
                        stk_op = STK_LEFT;
                        n_cur  = top_right;
                        n_lo   = IW'(top_mid + IW'(1));
                        n_hi   = stk_hi;
                        n_p    = stk_tag;
                    end else begin
                        // both children done: clear the tag, fold the minimum, pop
                        stk_op     = STK_POP;
                        node_we    = 1'b1;
                        node_waddr = stk_node;
                        node_wdata = {{DATA_W{1'b0}},
                                      (r_cmd == CMD_QUERY) ? stk_min : child_min};
                        n_ret      = child_min;
                    end
                end
            end
            S_OUT: begin
                out_ld = !r_ovalid || !i_out_stall;
            end
            default: begin
                n_ret = r_ret;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequential
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_qa  <= n_qa;
        r_qb  <= n_qb;
        r_val <= n_val;
        r_cur <= n_cur;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_p   <= n_p;
        r_ret <= n_ret;
    end

    // Output register: hold the result until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_ld) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_omin <= r_ret;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_range_minimum = r_omin;

endmodule
